[rtl/spr_pkg.sv]
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants for the servo pulse ramp controller: word
// layouts, command codes, register indexes and control/status bundles.
// ----------------------------------------------------------------------------
package spr_pkg;

  // Command codes carried in the op field.
  localparam logic [2:0] OP_ANGLE = 3'd0;
  localparam logic [2:0] OP_USEC  = 3'd1;
  localparam logic [2:0] OP_MOVE  = 3'd2;
  localparam logic [2:0] OP_TICK  = 3'd3;
  localparam logic [2:0] OP_STOP  = 3'd4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PULSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PULSE = 2'd1;

  // Angle scale and reset values.
  localparam logic [7:0]  ANGLE_FULL = 8'd180;
  localparam logic [6:0]  ANGLE_HALF = 7'd90;
  localparam logic [11:0] MIN_PULSE_RST = 12'd1000;
  localparam logic [11:0] MAX_PULSE_RST = 12'd2000;
  localparam logic [11:0] WIDTH_RST = 12'((32'd1000 + 32'd2000) / 2);

  // Shared divider geometry: two quotient bits per cycle.
  localparam int DIV_NUM_W = 30;
  localparam int DIV_DEN_W = 16;
  localparam int DIV_ITER  = DIV_NUM_W / 2;
  localparam int DIV_CNT_W = 4;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] value;
    logic [15:0] duration_ms;
  } in_word_t;

  typedef struct packed {
    logic [11:0] pulse_us;
    logic [12:0] compare_count;
    logic        pulsing;
    logic        moving;
    logic [7:0]  angle_deg;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic idle;
    logic latch;
    logic div_start;
    logic sel_read;
    logic apply;
    logic emit;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;
    logic out_free;
  } ctl_stat_t;

endpackage

[rtl/spr_divider.sv]
// ----------------------------------------------------------------------------
// spr_divider
// Restoring unsigned divider shared by all divisions of the block. It
// retires two quotient bits per cycle and leaves the quotient in quo.
// ----------------------------------------------------------------------------
module spr_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [spr_pkg::DIV_NUM_W-1:0] num,
  input  logic [spr_pkg::DIV_DEN_W-1:0] den,
  output logic                          busy,
  output logic [spr_pkg::DIV_NUM_W-1:0] quo
);

  logic [spr_pkg::DIV_DEN_W:0]   rem;
  logic [spr_pkg::DIV_DEN_W-1:0] den_r;
  logic [spr_pkg::DIV_CNT_W-1:0] cnt;
  logic [spr_pkg::DIV_NUM_W-1:0] quo_r;

  logic [spr_pkg::DIV_DEN_W:0]   r_a;
  logic [spr_pkg::DIV_DEN_W:0]   r_b;
  logic [spr_pkg::DIV_DEN_W+1:0] diff_a;
  logic [spr_pkg::DIV_DEN_W+1:0] diff_b;
  logic [spr_pkg::DIV_DEN_W:0]   r_a_next;
  logic [spr_pkg::DIV_DEN_W:0]   rem_next;
  logic                          bit_a;
  logic                          bit_b;

  // Two dependent shift-and-subtract steps.
  always_comb begin
    r_a      = {rem[spr_pkg::DIV_DEN_W-1:0], quo_r[spr_pkg::DIV_NUM_W-1]};
    diff_a   = {1'b0, r_a} - {2'b00, den_r};
    bit_a    = ~diff_a[spr_pkg::DIV_DEN_W+1];
    r_a_next = bit_a ? diff_a[spr_pkg::DIV_DEN_W:0] : r_a;
    r_b      = {r_a_next[spr_pkg::DIV_DEN_W-1:0], quo_r[spr_pkg::DIV_NUM_W-2]};
    diff_b   = {1'b0, r_b} - {2'b00, den_r};
    bit_b    = ~diff_b[spr_pkg::DIV_DEN_W+1];
    rem_next = bit_b ? diff_b[spr_pkg::DIV_DEN_W:0] : r_b;
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= spr_pkg::DIV_CNT_W'(spr_pkg::DIV_ITER - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Remainder and numerator/quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      quo_r <= {quo_r[spr_pkg::DIV_NUM_W-3:0], bit_a, bit_b};
      rem   <= rem_next;
    end
  end

  assign quo = quo_r;

endmodule

[rtl/spr_controller.sv]
// ----------------------------------------------------------------------------
// spr_controller
// Sequencer for one command word: optional first division, state update,
// readback division and hand-off to the output register.
// ----------------------------------------------------------------------------
module spr_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               div_busy,
  input  spr_pkg::ctl_stat_t stat,
  output spr_pkg::ctl_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD_A = 3'd1;
  localparam logic [2:0] S_DIV_A  = 3'd2;
  localparam logic [2:0] S_APPLY  = 3'd3;
  localparam logic [2:0] S_LOAD_B = 3'd4;
  localparam logic [2:0] S_DIV_B  = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state and command decode.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.idle  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_next = S_LOAD_A;
        end
      end
      S_LOAD_A: begin
        cmd.div_start = stat.need_div;
        state_next    = stat.need_div ? S_DIV_A : S_APPLY;
      end
      S_DIV_A: begin
        if (!div_busy) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = S_LOAD_B;
      end
      S_LOAD_B: begin
        cmd.div_start = 1'b1;
        cmd.sel_read  = 1'b1;
        state_next    = S_DIV_B;
      end
      S_DIV_B: begin
        cmd.sel_read = 1'b1;
        if (!div_busy) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        cmd.emit = stat.out_free;
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

[rtl/spr_datapath.sv]
// ----------------------------------------------------------------------------
// spr_datapath
// Limit registers, servo position and ramp state, divider operand
// selection and the output word register.
// ----------------------------------------------------------------------------
module spr_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  spr_pkg::ctl_cmd_t                 cmd,
  output spr_pkg::ctl_stat_t                stat,
  input  spr_pkg::in_word_t                 in_data,
  input  logic                              cfg_valid,
  input  logic [spr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [11:0]                       cfg_data,
  output logic [spr_pkg::DIV_NUM_W-1:0]     div_num,
  output logic [spr_pkg::DIV_DEN_W-1:0]     div_den,
  input  logic [spr_pkg::DIV_NUM_W-1:0]     div_quo,
  output logic                              out_valid,
  input  logic                              out_stall,
  output spr_pkg::out_word_t                out_data
);

  logic [11:0] min_pulse;
  logic [11:0] max_pulse;
  logic [11:0] width_now;
  logic        output_on;
  logic [11:0] ramp_start;
  logic [11:0] ramp_target;
  logic [15:0] ramp_length;
  logic [15:0] ramp_elapsed;
  logic [2:0]  op;
  logic [15:0] value;
  logic [15:0] duration;

  logic [11:0] lo;
  logic [11:0] span;
  logic [7:0]  deg;
  logic [15:0] elapsed_next;
  logic [15:0] elapsed_cl;
  logic [11:0] ramp_dist;
  logic        ramp_up;
  logic [11:0] above;
  logic [11:0] target_w;
  logic [11:0] ramp_point;
  logic [11:0] usec_w;

  // Effective limits; the lower one never exceeds the upper one.
  always_comb begin
    lo   = (min_pulse < max_pulse) ? min_pulse : max_pulse;
    span = max_pulse - lo;
    deg  = (value > 16'(spr_pkg::ANGLE_FULL)) ? spr_pkg::ANGLE_FULL : value[7:0];
  end

  // Ramp operands for the next tick.
  always_comb begin
    elapsed_next = (ramp_elapsed != 16'hFFFF) ? ramp_elapsed + 16'd1 : ramp_elapsed;
    elapsed_cl   = (elapsed_next > ramp_length) ? ramp_length : elapsed_next;
    ramp_up      = (ramp_target >= ramp_start);
    ramp_dist    = ramp_up ? (ramp_target - ramp_start) : (ramp_start - ramp_target);
  end

  // Position above the lower limit, saturated to the span.
  always_comb begin
    above = (width_now > lo) ? (width_now - lo) : 12'd0;
    if (above > span) begin
      above = span;
    end
  end

  // Divider operands: readback, ramp point or angle mapping.
  always_comb begin
    if (cmd.sel_read) begin
      div_num = spr_pkg::DIV_NUM_W'(above * spr_pkg::ANGLE_FULL)
              + spr_pkg::DIV_NUM_W'(span[11:1]);
      div_den = spr_pkg::DIV_DEN_W'(span);
    end else if (op == spr_pkg::OP_TICK) begin
      div_num = spr_pkg::DIV_NUM_W'(ramp_dist * elapsed_cl)
              + spr_pkg::DIV_NUM_W'(ramp_length[15:1]);
      div_den = ramp_length;
    end else begin
      div_num = spr_pkg::DIV_NUM_W'(deg * span)
              + spr_pkg::DIV_NUM_W'(spr_pkg::ANGLE_HALF);
      div_den = spr_pkg::DIV_DEN_W'(spr_pkg::ANGLE_FULL);
    end
  end

  // Candidate widths from the quotient and the clamped microsecond write.
  always_comb begin
    target_w   = lo + div_quo[11:0];
    ramp_point = ramp_up ? (ramp_start + div_quo[11:0]) : (ramp_start - div_quo[11:0]);
    if (value < 16'(lo)) begin
      usec_w = lo;
    end else if (value > 16'(max_pulse)) begin
      usec_w = max_pulse;
    end else begin
      usec_w = value[11:0];
    end
  end

  always_comb begin
    stat.need_div = (op == spr_pkg::OP_ANGLE) || (op == spr_pkg::OP_MOVE)
                 || ((op == spr_pkg::OP_TICK) && (ramp_length != 16'd0));
    stat.out_free = !out_valid || !out_stall;
  end

  // Latched command word.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op       <= in_data.op;
      value    <= in_data.value;
      duration <= in_data.duration_ms;
    end
  end

  // Limit registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_pulse <= spr_pkg::MIN_PULSE_RST;
      max_pulse <= spr_pkg::MAX_PULSE_RST;
    end else if (cfg_valid && cmd.idle) begin
      case (cfg_index)
        spr_pkg::CFG_MIN_PULSE: min_pulse <= cfg_data;
        spr_pkg::CFG_MAX_PULSE: max_pulse <= cfg_data;
        default: ;
      endcase
    end
  end

  // Position and ramp state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_now    <= spr_pkg::WIDTH_RST;
      output_on    <= 1'b0;
      ramp_start   <= '0;
      ramp_target  <= '0;
      ramp_length  <= '0;
      ramp_elapsed <= '0;
    end else if (cmd.apply) begin
      case (op)
        spr_pkg::OP_ANGLE: begin
          width_now   <= target_w;
          output_on   <= 1'b1;
          ramp_length <= '0;
        end
        spr_pkg::OP_USEC: begin
          width_now   <= usec_w;
          output_on   <= 1'b1;
          ramp_length <= '0;
        end
        spr_pkg::OP_MOVE: begin
          if ((ramp_length != 16'd0) && (target_w == ramp_target)) begin
            // A move to the running target leaves the move alone.
          end else if (!output_on || (duration == 16'd0) || (target_w == width_now)) begin
            width_now   <= target_w;
            output_on   <= 1'b1;
            ramp_length <= '0;
          end else begin
            ramp_start   <= width_now;
            ramp_target  <= target_w;
            ramp_length  <= duration;
            ramp_elapsed <= '0;
          end
        end
        spr_pkg::OP_TICK: begin
          if (ramp_length != 16'd0) begin
            ramp_elapsed <= elapsed_next;
            width_now    <= ramp_point;
            output_on    <= 1'b1;
            if (elapsed_next >= ramp_length) begin
              ramp_length <= '0;
            end
          end
        end
        spr_pkg::OP_STOP: begin
          ramp_length <= '0;
          output_on   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.pulse_us      <= width_now;
      out_data.compare_count <= {width_now, 1'b0};
      out_data.pulsing       <= output_on;
      out_data.moving        <= (ramp_length != 16'd0);
      out_data.angle_deg     <= (span == 12'd0) ? 8'd0 : div_quo[7:0];
    end
  end

endmodule

[rtl/servo_pulse_ramp_controller_core.sv]
// ----------------------------------------------------------------------------
// servo_pulse_ramp_controller_core
// Servo pulse width controller with limit registers and a linear timed
// move, built as a sequencer over a datapath and one shared divider.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake              Payload
//   -------   --------------------   ------------------------------------
//   in        in_valid / in_stall    in_data: op, value, duration_ms
//   out       out_valid / out_stall  out_data: pulse_us, compare_count,
//                                    pulsing, moving, angle_deg
//   cfg       cfg_valid / cfg_ready  cfg_index, cfg_data (limits)
//
// Each word runs through the shared divider twice when its update needs a
// division (angle write, timed move, tick during a move) and once otherwise,
// for the readback; the divider retires two quotient bits per cycle.
// Reset is synchronous and active high; limits return to 1000 and 2000 us
// and the position to 1500 us with the output off.
// A new word is accepted while the previous result waits in the output
// register; the sequencer holds only at its last step if that is still full.
// Configuration is taken while the sequencer is idle.
module servo_pulse_ramp_controller_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  spr_pkg::in_word_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output spr_pkg::out_word_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [spr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [11:0]                   cfg_data
);

  spr_pkg::ctl_cmd_t             cmd;
  spr_pkg::ctl_stat_t            stat;
  logic                          div_busy;
  logic [spr_pkg::DIV_NUM_W-1:0] div_num;
  logic [spr_pkg::DIV_DEN_W-1:0] div_den;
  logic [spr_pkg::DIV_NUM_W-1:0] div_quo;

  assign cfg_ready = cmd.idle;

  // Sequencer.
  spr_controller u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .div_busy (div_busy),
    .stat     (stat),
    .cmd      (cmd)
  );

  // State, operand selection and output register.
  spr_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .div_num   (div_num),
    .div_den   (div_den),
    .div_quo   (div_quo),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Shared divider.
  spr_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo)
  );

endmodule

[rtl/spr_checker.sv]
// ----------------------------------------------------------------------------
// spr_checker
// Port-level checks for the servo pulse ramp controller, bound to the
// top level.
// ----------------------------------------------------------------------------
module spr_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input spr_pkg::out_word_t out_data
);

  // An accepted word keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in consecutive cycles");

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result does not change.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

  // The compare count is the width in half microseconds.
  a_compare: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.compare_count == {out_data.pulse_us, 1'b0})
    else $error("compare count does not match pulse width");

  // A move only runs while the output is driven, and the angle stays in range.
  a_moving: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.moving || out_data.pulsing)
               && (out_data.angle_deg <= spr_pkg::ANGLE_FULL))
    else $error("moving without output, or angle out of range");

endmodule

bind servo_pulse_ramp_controller_core spr_checker u_spr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the servo pulse ramp controller core. A queue of
// commands feeds a valid/stall driver. Every accepted word runs through a
// predictor of the width, ramp and readback arithmetic. A monitor compares
// each returned status word, field by field, with the oldest prediction.
// The limit registers are swept through corner and random settings, with
// the block idle for each change.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 7;
  localparam int PHASES       = 11;
  localparam int PHASE_ITEMS  = 75;
  localparam int DRAIN_CYCLES = 60;
  localparam int LIMIT_NS     = 10_000_000;

  // Op codes that the block leaves unused.
  localparam logic [2:0] OP_SPARE_LO = spr_pkg::OP_STOP + 3'd1;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  // Register indexes past the end of the register list.
  localparam logic [spr_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [spr_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  spr_pkg::in_word_t             in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  spr_pkg::out_word_t            out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [spr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [11:0]                   cfg_data = '0;

  // Predicted servo state and limit registers.
  logic [11:0] lim_min   = spr_pkg::MIN_PULSE_RST;
  logic [11:0] lim_max   = spr_pkg::MAX_PULSE_RST;
  logic [11:0] pos_us    = spr_pkg::WIDTH_RST;
  logic        drive_on  = 1'b0;
  logic [11:0] ramp_from = '0;
  logic [11:0] ramp_to   = '0;
  logic [15:0] ramp_len  = '0;
  logic [15:0] ramp_done = '0;

  spr_pkg::in_word_t  pending_cmds[$];
  spr_pkg::out_word_t expected_status_q[$];

  int  queued_total = 0;
  int  cmds_sent = 0;
  int  results_seen = 0;
  int  cfg_writes = 0;
  int  mismatch_count = 0;
  int  gap_left = 0;
  int  hold_left = 0;
  int  stall_pick;
  bit  gaps_on = 1'b1;
  bit  stalls_on = 1'b1;

  servo_pulse_ramp_controller_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // The lower limit never exceeds the upper one.
  function automatic logic [11:0] low_limit();
    return (lim_min < lim_max) ? lim_min : lim_max;
  endfunction

  // Angle in degrees, clamped to full scale, mapped onto the limits with rounding.
  function automatic logic [11:0] angle_to_us(logic [15:0] deg);
    logic [31:0] d;
    logic [31:0] span;
    d = (deg > spr_pkg::ANGLE_FULL) ? 32'(spr_pkg::ANGLE_FULL) : 32'(deg);
    span = lim_max - low_limit();
    return 12'(low_limit() + (d * span + spr_pkg::ANGLE_HALF) / spr_pkg::ANGLE_FULL);
  endfunction

  // Any width write clamps to the limits, ends a move and turns the output on.
  function automatic void put_width(logic [15:0] w);
    logic [15:0] lo;
    lo = low_limit();
    if (w < lo) begin
      w = lo;
    end else if (w > lim_max) begin
      w = lim_max;
    end
    ramp_len = '0;
    pos_us = w[11:0];
    drive_on = 1'b1;
  endfunction

  // Width read back as rounded degrees, saturating when outside the limits.
  function automatic logic [7:0] angle_readback();
    logic [31:0] lo;
    logic [31:0] span;
    logic [31:0] above;
    lo = low_limit();
    span = lim_max - lo;
    if (span == 0) return '0;
    above = (pos_us > lo) ? pos_us - lo : 32'd0;
    if (above > span) above = span;
    return 8'((above * spr_pkg::ANGLE_FULL + span / 2) / span);
  endfunction

  // Linear interpolation from the start width, ties rounded away from the start.
  function automatic logic [11:0] ramp_point();
    logic [63:0] e;
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] advance;
    e = ramp_done;
    n = ramp_len;
    if (n == 0) return ramp_to;
    if (e > n) e = n;
    if (ramp_to >= ramp_from) begin
      d = ramp_to - ramp_from;
      advance = (d * e + n / 2) / n;
      return 12'(ramp_from + advance);
    end
    d = ramp_from - ramp_to;
    advance = (d * e + n / 2) / n;
    return 12'(ramp_from - advance);
  endfunction

  // Applies one command to the predicted state and returns the status word.
  function automatic spr_pkg::out_word_t servo_step(spr_pkg::in_word_t cmd);
    spr_pkg::out_word_t res;
    logic [11:0]        tgt;
    case (cmd.op)
      spr_pkg::OP_ANGLE: put_width(angle_to_us(cmd.value));
      spr_pkg::OP_USEC:  put_width(cmd.value);
      spr_pkg::OP_MOVE: begin
        tgt = angle_to_us(cmd.value);
        // A move to the target already being ramped to leaves it running.
        if (!(ramp_len != 0 && tgt == ramp_to)) begin
          if (!drive_on || cmd.duration_ms == 0 || tgt == pos_us) begin
            put_width(tgt);
          end else begin
            ramp_from = pos_us;
            ramp_to = tgt;
            ramp_len = cmd.duration_ms;
            ramp_done = '0;
          end
        end
      end
      spr_pkg::OP_TICK: begin
        if (ramp_len != 0) begin
          if (ramp_done != '1) ramp_done++;
          pos_us = ramp_point();
          drive_on = 1'b1;
          if (ramp_done >= ramp_len) ramp_len = '0;
        end
      end
      spr_pkg::OP_STOP: begin
        ramp_len = '0;
        drive_on = 1'b0;
      end
      default: ;
    endcase
    res.pulse_us = pos_us;
    res.compare_count = {pos_us, 1'b0};
    res.pulsing = drive_on;
    res.moving = (ramp_len != 0);
    res.angle_deg = angle_readback();
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic void push_cmd(logic [2:0] op, logic [15:0] value, logic [15:0] dur);
    spr_pkg::in_word_t w;
    w.op = op;
    w.value = value;
    w.duration_ms = dur;
    pending_cmds.push_back(w);
    queued_total++;
  endfunction

  function automatic logic [15:0] rand16();
    return 16'($urandom);
  endfunction

  // Mostly legal angles, with some far above full scale.
  function automatic logic [15:0] rand_angle();
    if ($urandom_range(0, 3) == 0) return rand16();
    return 16'($urandom_range(0, spr_pkg::ANGLE_FULL));
  endfunction

  function automatic logic [15:0] rand_usec();
    if ($urandom_range(0, 1) == 0) return rand16();
    return 16'($urandom_range(0, 4200));
  endfunction

  // Input gaps: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  // One random stretch of commands. About half are a timed move followed by ticks.
  task automatic queue_random_burst();
    int          kind;
    int          n;
    int          r;
    logic [15:0] deg;
    logic [15:0] dur;
    kind = $urandom_range(0, 99);
    if (kind < 50) begin
      if ($urandom_range(0, 2) == 0) push_cmd(spr_pkg::OP_USEC, rand_usec(), rand16());
      deg = rand_angle();
      dur = 16'($urandom_range(1, 12));
      push_cmd(spr_pkg::OP_MOVE, deg, dur);
      n = $urandom_range(0, dur + 2);
      repeat (n) begin
        r = $urandom_range(0, 19);
        if (r == 0) begin
          push_cmd(spr_pkg::OP_MOVE, deg, 16'($urandom_range(0, 30)));
        end else if (r == 1) begin
          push_cmd(spr_pkg::OP_MOVE, rand_angle(), 16'($urandom_range(1, 12)));
        end else begin
          push_cmd(spr_pkg::OP_TICK, rand16(), rand16());
        end
      end
    end else if (kind < 65) begin
      push_cmd(spr_pkg::OP_ANGLE, rand_angle(), rand16());
    end else if (kind < 75) begin
      push_cmd(spr_pkg::OP_USEC, rand_usec(), rand16());
    end else if (kind < 83) begin
      repeat ($urandom_range(1, 5)) push_cmd(spr_pkg::OP_TICK, rand16(), rand16());
    end else if (kind < 89) begin
      push_cmd(spr_pkg::OP_STOP, rand16(), rand16());
    end else if (kind < 93) begin
      push_cmd(spr_pkg::OP_MOVE, rand_angle(), '0);
    end else if (kind < 97) begin
      push_cmd(spr_pkg::OP_MOVE, rand_angle(), rand16());
    end else begin
      push_cmd(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), rand16(), rand16());
    end
  endtask

  // Waits until every queued command has been taken and every result checked.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || expected_status_q.size() != 0);
  endtask

  // Register write; the predictor copy changes at the same edge.
  task automatic write_reg(logic [spr_pkg::CFG_IDX_W-1:0] idx, logic [11:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      spr_pkg::CFG_MIN_PULSE: lim_min = data;
      spr_pkg::CFG_MAX_PULSE: lim_max = data;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Both limits in random order, now and then with a write to a spare index.
  task automatic set_limits(logic [11:0] mn, logic [11:0] mx);
    if ($urandom_range(0, 1) == 0) begin
      write_reg(spr_pkg::CFG_MIN_PULSE, mn);
      write_reg(spr_pkg::CFG_MAX_PULSE, mx);
    end else begin
      write_reg(spr_pkg::CFG_MAX_PULSE, mx);
      write_reg(spr_pkg::CFG_MIN_PULSE, mn);
    end
    if ($urandom_range(0, 2) == 0) begin
      write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 12'($urandom));
    end
  endtask

  task automatic note_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH on result %0d: %s", $time, results_seen, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // --------------------------------------------------------------------------
  // Driver: presents queued commands and predicts each accepted word.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_status_q.push_back(servo_step(in_data));
        cmds_sent++;
      end
      // A stalled word stays on the bus unchanged.
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          in_data <= pending_cmds.pop_front();
          in_valid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: random back-pressure and field-by-field comparison.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_status_q.size() == 0) begin
          note_mismatch("status word with no command outstanding");
        end else begin
          check_status(expected_status_q.pop_front());
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!stalls_on) begin
        out_stall <= 1'b0;
      end else begin
        stall_pick = $urandom_range(0, 99);
        if (stall_pick < 20) begin
          hold_left = (stall_pick < 2) ? $urandom_range(20, 90) : $urandom_range(0, 3);
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  task automatic check_status(spr_pkg::out_word_t want);
    check_field("pulse_us", out_data.pulse_us, want.pulse_us);
    check_field("compare_count", out_data.compare_count, want.compare_count);
    check_field("pulsing", out_data.pulsing, want.pulsing);
    check_field("moving", out_data.moving, want.moving);
    check_field("angle_deg", out_data.angle_deg, want.angle_deg);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  logic [11:0] corner_min [7] = '{12'd0, 12'd4095, 12'd2000, 12'd1500, 12'd0,
                                  12'd4095, 12'd500};
  logic [11:0] corner_max [7] = '{12'd4095, 12'd0, 12'd1000, 12'd1500, 12'd0,
                                  12'd4095, 12'd2500};

  initial begin
    logic [11:0] mn;
    logic [11:0] mx;
    int          base;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed commands at the reset limits of 1000 and 2000 us.
    push_cmd(spr_pkg::OP_TICK, '0, '0);                  // tick with nothing running
    push_cmd(spr_pkg::OP_MOVE, '0, 16'd100);             // output off: applies at once
    push_cmd(spr_pkg::OP_ANGLE, 16'd180, '0);
    push_cmd(spr_pkg::OP_ANGLE, 16'hFFFF, 16'hFFFF);     // far above full scale
    push_cmd(spr_pkg::OP_ANGLE, 16'h0100, '0);           // low byte zero, still clamped
    push_cmd(spr_pkg::OP_ANGLE, '0, '0);
    push_cmd(spr_pkg::OP_USEC, '0, '0);                  // below the lower limit
    push_cmd(spr_pkg::OP_USEC, 16'hFFFF, '0);            // above the upper limit
    push_cmd(spr_pkg::OP_USEC, 16'd1234, '0);
    push_cmd(spr_pkg::OP_MOVE, 16'd90, '0);              // zero duration
    push_cmd(spr_pkg::OP_MOVE, 16'd90, 16'd7);           // already at the target
    push_cmd(spr_pkg::OP_MOVE, '0, 16'd4);               // real ramp down
    push_cmd(spr_pkg::OP_TICK, '0, '0);
    push_cmd(spr_pkg::OP_MOVE, '0, 16'd9);               // same target while moving
    repeat (3) push_cmd(spr_pkg::OP_TICK, 16'hFFFF, 16'hFFFF);
    push_cmd(spr_pkg::OP_TICK, '0, '0);                  // ramp already finished
    push_cmd(spr_pkg::OP_MOVE, 16'd180, 16'hFFFF);       // longest move
    push_cmd(spr_pkg::OP_TICK, '0, '0);
    push_cmd(spr_pkg::OP_STOP, '0, '0);
    push_cmd(spr_pkg::OP_TICK, '0, '0);                  // output off, nothing moving
    push_cmd(OP_SPARE_LO, '0, '0);
    push_cmd(3'(OP_SPARE_LO + 3'd1), 16'hFFFF, 16'hFFFF);
    push_cmd(OP_SPARE_HI, 16'h5A5A, 16'hA5A5);
    wait_drained();

    // Random phases over corner and random limit settings.
    for (int i = 0; i < PHASES; i++) begin
      if (i < 7) begin
        mn = corner_min[i];
        mx = corner_max[i];
      end else begin
        mn = 12'($urandom_range(0, 3000));
        mx = 12'($urandom_range(mn, 4095));
        if (i == PHASES - 2) begin
          // Inverted pair: the effective window collapses to the maximum.
          mx = 12'($urandom_range(0, mn));
        end
      end
      set_limits(mn, mx);
      @(negedge clk);
      gaps_on = (i % 4 == 0) || (i % 4 == 2);
      stalls_on = (i % 4 == 0) || (i % 4 == 3);
      base = queued_total;
      while (queued_total - base < PHASE_ITEMS) queue_random_burst();
      wait_drained();
    end

    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d commands and %0d status words over %0d limit settings",
             cmds_sent, results_seen, PHASES + 1);
    $display("(%0d register writes, %0d mismatches)", cfg_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("servo_pulse_ramp_controller_core verification clean");
    end else begin
      $display("servo_pulse_ramp_controller_core verification failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(LIMIT_NS);
    $display("Timeout with %0d commands pending and %0d results outstanding",
             pending_cmds.size(), expected_status_q.size());
    $display("servo_pulse_ramp_controller_core verification failed");
    $finish;
  end

endmodule

[files.f]
rtl/spr_pkg.sv
rtl/spr_divider.sv
rtl/spr_controller.sv
rtl/spr_datapath.sv
rtl/servo_pulse_ramp_controller_core.sv
rtl/spr_checker.sv
verif/tb.sv
